// ----- rtl/uti_pkg.sv -----
package uti_pkg;

   // Fixed field widths
   localparam int WL_W  = 24;
   localparam int Q_W   = 20;
   localparam int PC_W  = 11;
   localparam int IDX_W = 10;

   // Quotient bits kept by the blend divider; larger magnitudes saturate anyway
   localparam int QUO_W = 21;

   localparam logic signed [Q_W-1:0] Q_MAX = 20'sh7FFFF;
   localparam logic signed [Q_W-1:0] Q_MIN = 20'sh80000;

   typedef enum logic {
      FUNC_WRITE  = 1'b0,
      FUNC_LOOKUP = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      CSR_WL_MIN      = 2'd0,
      CSR_WL_MAX      = 2'd1,
      CSR_POINT_COUNT = 2'd2
   } csr_index_type;

   typedef struct packed {
      func_type                func;
      logic [IDX_W-1:0]        entry_index;
      logic signed [Q_W-1:0]   entry_real;
      logic signed [Q_W-1:0]   entry_extinction;
      logic [WL_W-1:0]         wavelength;
   } req_type;

   typedef struct packed {
      logic signed [Q_W-1:0]   index_real;
      logic signed [Q_W-1:0]   index_extinction;
   } rsp_type;

   // Segment finder to store stage
   typedef struct packed {
      logic     valid;
      func_type func;
      logic     wen;
      logic     zero_span;
   } seg_ctl_type;

   // Store stage to blend pipeline
   typedef struct packed {
      logic valid;
      logic zero_span;
   } blend_ctl_type;

endpackage

// ----- rtl/uti_ram.sv -----
module uti_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/uti_segment.sv -----
module uti_segment import uti_pkg::*; #(
   parameter int TABLE_DEPTH = 1024,
   localparam int AW   = $clog2(TABLE_DEPTH),
   localparam int NW   = WL_W + AW,
   localparam int NUMW = NW + 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   in_valid,
   input  req_type                in_req,
   input  logic [WL_W-1:0]        wl_min,
   input  logic [WL_W-1:0]        wl_max,
   input  logic [PC_W-1:0]        point_count,
   output seg_ctl_type            out_ctl,
   output logic [AW-1:0]          out_k,
   output logic [AW-1:0]          out_k1,
   output logic [NUMW-1:0]        out_num,
   output logic [WL_W-1:0]        out_span,
   output logic [AW-1:0]          out_waddr,
   output logic [2*Q_W-1:0]       out_wdata
);

   typedef struct packed {
      logic              valid;
      func_type          func;
      logic              wen;
      logic [AW-1:0]     waddr;
      logic [2*Q_W-1:0]  wdata;
   } carry_type;

   typedef struct packed {
      carry_type         c;
      logic [NUMW-1:0]   n;
      logic [NW-1:0]     l;
      logic [NW-1:0]     rem;
      logic [AW-1:0]     q;
      logic [WL_W-1:0]   sabs;
      logic [AW-1:0]     m;
      logic              zero;
      logic              dneg;
      logic              ovf;
   } div_type;

   // Stage 0: offsets from the range start, clamped segment count
   carry_type          c0_ff, c0_in;
   logic signed [24:0] d0_ff, d0_in, s0_ff, s0_in;
   logic [AW-1:0]      m0_ff, m0_in;

   always_comb begin
      int unsigned nb;
      nb = 32'(point_count);
      if (nb < 32'd2) begin
         nb = 32'd2;
      end
      if (nb > 32'(TABLE_DEPTH)) begin
         nb = 32'(TABLE_DEPTH);
      end
      m0_in       = AW'(nb - 32'd1);
      c0_in.valid = in_valid;
      c0_in.func  = in_req.func;
      c0_in.wen   = (in_req.func == FUNC_WRITE) &&
                    (32'(in_req.entry_index) < 32'(TABLE_DEPTH));
      c0_in.waddr = AW'(in_req.entry_index);
      c0_in.wdata = {in_req.entry_real, in_req.entry_extinction};
      d0_in = $signed({1'b0, in_req.wavelength}) - $signed({1'b0, wl_min});
      s0_in = $signed({1'b0, wl_max}) - $signed({1'b0, wl_min});
   end

   // Stage 1: fold a reversed range onto a positive span
   carry_type          c1_ff;
   logic signed [24:0] d1_ff, d1_in;
   logic [WL_W-1:0]    sabs1_ff, sabs1_in;
   logic [AW-1:0]      m1_ff;
   logic               zero1_ff, zero1_in;

   always_comb begin
      if (s0_ff[24]) begin
         sabs1_in = WL_W'(-s0_ff);
         d1_in    = -d0_ff;
      end else begin
         sabs1_in = WL_W'(s0_ff);
         d1_in    = d0_ff;
      end
      zero1_in = (s0_ff == '0);
   end

   // Stage 2: dividend D*M and end-segment offset (M-1)*S
   carry_type             c2_ff;
   logic signed [NUMW-1:0] n2_ff, n2_in;
   logic [NW-1:0]         l2_ff, l2_in;
   logic [WL_W-1:0]       sabs2_ff;
   logic [AW-1:0]         m2_ff;
   logic                  zero2_ff, dneg2_ff;

   always_comb begin
      n2_in = d1_ff * $signed({1'b0, m1_ff});
      l2_in = (m1_ff - 1'b1) * sabs1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c0_ff.valid <= 1'b0;
         c1_ff.valid <= 1'b0;
         c2_ff.valid <= 1'b0;
      end else if (adv) begin
         c0_ff    <= c0_in;
         d0_ff    <= d0_in;
         s0_ff    <= s0_in;
         m0_ff    <= m0_in;
         c1_ff    <= c0_ff;
         d1_ff    <= d1_in;
         sabs1_ff <= sabs1_in;
         m1_ff    <= m0_ff;
         zero1_ff <= zero1_in;
         c2_ff    <= c1_ff;
         n2_ff    <= n2_in;
         l2_ff    <= l2_in;
         sabs2_ff <= sabs1_ff;
         m2_ff    <= m1_ff;
         zero2_ff <= zero1_ff;
         dneg2_ff <= d1_ff[24];
      end
   end

   // Stage 3 and on: restoring division, one quotient bit per stage
   div_type dv_ff [AW+1];

   for (genvar g = 0; g <= AW; g++) begin : g_div
      div_type dv_in;
      if (g == 0) begin : g_head
         always_comb begin
            dv_in      = '0;
            dv_in.c    = c2_ff;
            dv_in.n    = n2_ff;
            dv_in.l    = l2_ff;
            dv_in.rem  = n2_ff[NW-1:0];
            dv_in.sabs = sabs2_ff;
            dv_in.m    = m2_ff;
            dv_in.zero = zero2_ff;
            dv_in.dneg = dneg2_ff;
            dv_in.ovf  = !dneg2_ff && (n2_ff[NW-1:0] >= {sabs2_ff, {AW{1'b0}}});
         end
      end else begin : g_step
         localparam int J = AW - g;
         logic [NW-1:0] trial;
         always_comb begin
            dv_in = dv_ff[g-1];
            trial = NW'(dv_ff[g-1].sabs) << J;
            if (dv_ff[g-1].rem >= trial) begin
               dv_in.rem  = dv_ff[g-1].rem - trial;
               dv_in.q[J] = 1'b1;
            end
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[g].c.valid <= 1'b0;
         end else if (adv) begin
            dv_ff[g] <= dv_in;
         end
      end
   end

   // Final stage: clamp the segment and form the in-segment numerator
   seg_ctl_type      ctl_ff, ctl_in;
   logic [AW-1:0]    k_ff, k_in, k1_ff, waddr_ff;
   logic [NUMW-1:0]  num_ff, num_in;
   logic [WL_W-1:0]  span_ff;
   logic [2*Q_W-1:0] wdata_ff;
   logic [AW-1:0]    mm1;
   logic             big;

   always_comb begin
      mm1 = dv_ff[AW].m - 1'b1;
      big = dv_ff[AW].ovf || (dv_ff[AW].q > mm1);
      if (dv_ff[AW].dneg || dv_ff[AW].zero) begin
         k_in   = '0;
         num_in = dv_ff[AW].n;
      end else if (big) begin
         k_in   = mm1;
         num_in = $signed(dv_ff[AW].n) - $signed({1'b0, dv_ff[AW].l});
      end else begin
         k_in   = dv_ff[AW].q;
         num_in = {1'b0, dv_ff[AW].rem};
      end
      ctl_in.valid     = dv_ff[AW].c.valid;
      ctl_in.func      = dv_ff[AW].c.func;
      ctl_in.wen       = dv_ff[AW].c.wen;
      ctl_in.zero_span = dv_ff[AW].zero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (adv) begin
         ctl_ff   <= ctl_in;
         k_ff     <= k_in;
         k1_ff    <= k_in + 1'b1;
         num_ff   <= num_in;
         span_ff  <= dv_ff[AW].sabs;
         waddr_ff <= dv_ff[AW].c.waddr;
         wdata_ff <= dv_ff[AW].c.wdata;
      end
   end

   assign out_ctl   = ctl_ff;
   assign out_k     = k_ff;
   assign out_k1    = k1_ff;
   assign out_num   = num_ff;
   assign out_span  = span_ff;
   assign out_waddr = waddr_ff;
   assign out_wdata = wdata_ff;

endmodule

// ----- rtl/uti_blend.sv -----
module uti_blend import uti_pkg::*; #(
   parameter int TABLE_DEPTH = 1024,
   localparam int AW   = $clog2(TABLE_DEPTH),
   localparam int NUMW = WL_W + AW + 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      adv,
   input  blend_ctl_type             in_ctl,
   input  logic [NUMW-1:0]           in_num,
   input  logic [WL_W-1:0]           in_span,
   input  logic [1:0][Q_W-1:0]       in_a,
   input  logic [1:0][Q_W-1:0]       in_b,
   output logic                      out_valid,
   output rsp_type                   out_rsp
);

   localparam int PHW = Q_W + 1 + NUMW - 21;
   localparam int PLW = Q_W + 1 + 22;
   localparam int PW  = Q_W + 1 + NUMW;
   localparam int NST = 6 + QUO_W;

   // Lane 1 carries the real part, lane 0 the extinction
   typedef struct packed {
      logic                      valid;
      logic                      zero;
      logic [WL_W-1:0]           span;
      logic [NUMW-1:0]           num;
      logic [1:0][Q_W-1:0]       a;
      logic [1:0][Q_W:0]         diff;
      logic [1:0][PLW-1:0]       pl;
      logic [1:0][PHW-1:0]       ph;
      logic [1:0][PW-1:0]        p;
      logic [1:0]                neg;
      logic [1:0]                ovf;
      logic [1:0][QUO_W-1:0]     q;
   } blend_type;

   blend_type st_ff [NST];

   for (genvar g = 0; g < NST; g++) begin : g_stage
      blend_type nx_in;
      if (g == 0) begin : g_diff
         // Segment slope b - a
         always_comb begin
            nx_in       = '0;
            nx_in.valid = in_ctl.valid;
            nx_in.zero  = in_ctl.zero_span;
            nx_in.span  = in_span;
            nx_in.num   = in_num;
            nx_in.a     = in_a;
            for (int l = 0; l < 2; l++) begin
               nx_in.diff[l] = $signed({in_b[l][Q_W-1], in_b[l]}) -
                               $signed({in_a[l][Q_W-1], in_a[l]});
            end
         end
      end else if (g == 1) begin : g_mul
         // Split product: slope times low and high parts of the numerator
         always_comb begin
            nx_in = st_ff[g-1];
            for (int l = 0; l < 2; l++) begin
               nx_in.pl[l] = $signed(st_ff[g-1].diff[l]) *
                             $signed({1'b0, st_ff[g-1].num[20:0]});
               nx_in.ph[l] = $signed(st_ff[g-1].diff[l]) *
                             $signed(st_ff[g-1].num[NUMW-1:21]);
            end
         end
      end else if (g == 2) begin : g_sum
         always_comb begin
            nx_in = st_ff[g-1];
            for (int l = 0; l < 2; l++) begin
               nx_in.p[l] = (PW'($signed(st_ff[g-1].ph[l])) <<< 21) +
                            PW'($signed(st_ff[g-1].pl[l]));
            end
         end
      end else if (g == 3) begin : g_mag
         always_comb begin
            nx_in = st_ff[g-1];
            for (int l = 0; l < 2; l++) begin
               nx_in.neg[l] = st_ff[g-1].p[l][PW-1];
               if (st_ff[g-1].p[l][PW-1]) begin
                  nx_in.p[l] = ~st_ff[g-1].p[l] + 1'b1;
               end
            end
         end
      end else if (g == 4) begin : g_round
         // Half the span added for round-half-away
         always_comb begin
            nx_in = st_ff[g-1];
            for (int l = 0; l < 2; l++) begin
               nx_in.p[l] = st_ff[g-1].p[l] + PW'(st_ff[g-1].span[WL_W-1:1]);
            end
         end
      end else if (g == 5) begin : g_ovf
         // Quotient beyond QUO_W bits saturates the result
         always_comb begin
            nx_in = st_ff[g-1];
            for (int l = 0; l < 2; l++) begin
               nx_in.ovf[l] = st_ff[g-1].p[l] >= (PW'(st_ff[g-1].span) << QUO_W);
               nx_in.q[l]   = '0;
            end
         end
      end else begin : g_step
         localparam int J = QUO_W - 1 - (g - 6);
         logic [PW-1:0] trial;
         always_comb begin
            nx_in = st_ff[g-1];
            trial = PW'(st_ff[g-1].span) << J;
            for (int l = 0; l < 2; l++) begin
               if (st_ff[g-1].p[l] >= trial) begin
                  nx_in.p[l]    = st_ff[g-1].p[l] - trial;
                  nx_in.q[l][J] = 1'b1;
               end
            end
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            st_ff[g].valid <= 1'b0;
         end else if (adv) begin
            st_ff[g] <= nx_in;
         end
      end
   end

   // Final add of a, saturation to Q4.16
   logic                  valid_ff;
   logic [1:0][Q_W-1:0]   res_ff, res_in;

   always_comb begin
      logic [QUO_W-1:0]  qe;
      logic signed [22:0] sum;
      for (int l = 0; l < 2; l++) begin
         qe = st_ff[NST-1].ovf[l] ? '1 : st_ff[NST-1].q[l];
         if (st_ff[NST-1].neg[l]) begin
            sum = $signed({{3{st_ff[NST-1].a[l][Q_W-1]}}, st_ff[NST-1].a[l]}) -
                  $signed({2'b00, qe});
         end else begin
            sum = $signed({{3{st_ff[NST-1].a[l][Q_W-1]}}, st_ff[NST-1].a[l]}) +
                  $signed({2'b00, qe});
         end
         if (st_ff[NST-1].zero) begin
            res_in[l] = st_ff[NST-1].a[l];
         end else if (sum > 23'(Q_MAX)) begin
            res_in[l] = Q_MAX;
         end else if (sum < 23'(Q_MIN)) begin
            res_in[l] = Q_MIN;
         end else begin
            res_in[l] = sum[Q_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= st_ff[NST-1].valid;
         res_ff   <= res_in;
      end
   end

   assign out_valid                = valid_ff;
   assign out_rsp.index_real       = res_ff[1];
   assign out_rsp.index_extinction = res_ff[0];

endmodule

// ----- rtl/uniform_table_interpolator.sv -----
// Uniform table interpolator
//
// Request beats on req_* either load one table entry (func = write) or ask
// for the linearly interpolated (real, extinction) pair at a wavelength
// (func = lookup). Each lookup gives exactly one response beat on rsp_*,
// writes give none. Results come back in request order.
// csr_* sets the range start, range end and point count; write it only
// while no lookup is in flight.
//
// Throughput is one beat per cycle while no held response stalls the
// pipeline. Requests pass through the segment divider (one quotient bit
// per stage) and the 21-stage blend divider. Table writes take effect in
// request order at the table stage.
//
// Reset clears all valid bits and sets the range registers to their
// defaults; table contents are undefined until written.
// When rsp_stall is high with a response waiting, the whole pipeline
// freezes and req_stall is raised in the same cycle; nothing is dropped.
module uniform_table_interpolator import uti_pkg::*; #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,
   input  logic              csr_write_en,
   input  logic [1:0]        csr_index,
   input  logic [WL_W-1:0]   csr_wdata
);

   localparam int AW   = $clog2(TABLE_DEPTH);
   localparam int NUMW = WL_W + AW + 1;

   logic adv;

   // Global advance: everything moves unless the response is held
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   // Configuration registers
   logic [WL_W-1:0] wl_min_ff, wl_max_ff;
   logic [PC_W-1:0] pc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wl_min_ff <= '0;
         wl_max_ff <= '1;
         pc_ff     <= PC_W'(2);
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_WL_MIN:      wl_min_ff <= csr_wdata;
            CSR_WL_MAX:      wl_max_ff <= csr_wdata;
            CSR_POINT_COUNT: pc_ff     <= csr_wdata[PC_W-1:0];
            default: ;
         endcase
      end
   end

   // Segment finder
   seg_ctl_type      seg_ctl;
   logic [AW-1:0]    seg_k, seg_k1, seg_waddr;
   logic [NUMW-1:0]  seg_num;
   logic [WL_W-1:0]  seg_span;
   logic [2*Q_W-1:0] seg_wdata;

   uti_segment #(.TABLE_DEPTH(TABLE_DEPTH)) u_segment (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (req_valid),
      .in_req      (req_data),
      .wl_min      (wl_min_ff),
      .wl_max      (wl_max_ff),
      .point_count (pc_ff),
      .out_ctl     (seg_ctl),
      .out_k       (seg_k),
      .out_k1      (seg_k1),
      .out_num     (seg_num),
      .out_span    (seg_span),
      .out_waddr   (seg_waddr),
      .out_wdata   (seg_wdata)
   );

   // Table stage: two copies so entries k and k+1 read together
   logic             tbl_we;
   logic [2*Q_W-1:0] rd_a, rd_b;

   assign tbl_we = adv && seg_ctl.valid && (seg_ctl.func == FUNC_WRITE) && seg_ctl.wen;

   uti_ram #(.WIDTH(2*Q_W), .DEPTH(TABLE_DEPTH)) u_ram_lo (
      .clock (clock),
      .we    (tbl_we),
      .waddr (seg_waddr),
      .wdata (seg_wdata),
      .re    (adv),
      .raddr (seg_k),
      .rdata (rd_a)
   );

   uti_ram #(.WIDTH(2*Q_W), .DEPTH(TABLE_DEPTH)) u_ram_hi (
      .clock (clock),
      .we    (tbl_we),
      .waddr (seg_waddr),
      .wdata (seg_wdata),
      .re    (adv),
      .raddr (seg_k1),
      .rdata (rd_b)
   );

   blend_ctl_type    rd_ctl_ff;
   logic [NUMW-1:0]  rd_num_ff;
   logic [WL_W-1:0]  rd_span_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ctl_ff.valid <= 1'b0;
      end else if (adv) begin
         rd_ctl_ff.valid     <= seg_ctl.valid && (seg_ctl.func == FUNC_LOOKUP);
         rd_ctl_ff.zero_span <= seg_ctl.zero_span;
         rd_num_ff           <= seg_num;
         rd_span_ff          <= seg_span;
      end
   end

   // Blend and output register
   uti_blend #(.TABLE_DEPTH(TABLE_DEPTH)) u_blend (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_ctl    (rd_ctl_ff),
      .in_num    (rd_num_ff),
      .in_span   (rd_span_ff),
      .in_a      (rd_a),
      .in_b      (rd_b),
      .out_valid (rsp_valid),
      .out_rsp   (rsp_data)
   );

endmodule

// ----- rtl/uti_checker.sv -----
module uti_checker import uti_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // A held response keeps its beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // Back pressure only comes from a held response
   a_stall_src: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a held response");

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind uniform_table_interpolator uti_checker u_checker (.*);
